[hdl/imbw_pkg.sv]
// ----------------------------------------------------------------------------
// imbw_pkg - shared types and constants for the inode block map walker
// Beat layouts, walk phases and result codes used by every module.
// ----------------------------------------------------------------------------
package imbw_pkg;

  // Geometry of the block map
  localparam int unsigned PTRS_PER_BLOCK = 256;
  localparam int unsigned DIRECT_SLOTS   = 8;
  localparam int unsigned PPB_BITS       = $clog2(PTRS_PER_BLOCK);
  localparam int unsigned LARGE_SINGLE_SLOTS = 7;
  localparam int unsigned LARGE_SINGLE_SPAN  = LARGE_SINGLE_SLOTS * PTRS_PER_BLOCK;
  localparam int unsigned DOUBLE_SPAN        = PTRS_PER_BLOCK * PTRS_PER_BLOCK;
  localparam int unsigned SMALL_SINGLE_SLOT  = 8;
  localparam int unsigned SMALL_DOUBLE_SLOT  = 9;
  localparam int unsigned LARGE_DOUBLE_SLOT  = 7;
  localparam int unsigned SLOT_COUNT         = 10;
  localparam int unsigned SLOT_IDX_W         = $clog2(SLOT_COUNT);

  // Field widths
  localparam int unsigned IDX_W   = 17;
  localparam int unsigned WORD_W  = 16;
  localparam int unsigned WIDX_W  = 8;
  localparam int unsigned STAT_W  = 2;

  // Stream widths
  localparam int unsigned IN_DATA_W  = 200;
  localparam int unsigned OUT_DATA_W = 48;

  // Input beat selector (tuser)
  localparam logic MODE_LOOKUP   = 1'b0;
  localparam logic MODE_RESPONSE = 1'b1;

  // Result beat kind (tuser)
  localparam logic KIND_READ_REQ = 1'b0;
  localparam logic KIND_ANSWER   = 1'b1;

  // Answer status codes
  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_RANGE     = 2'd1;
  localparam logic [STAT_W-1:0] ST_READ_FAIL = 2'd2;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_SINGLE = 2'd1,
    PH_OUTER  = 2'd2,
    PH_INNER  = 2'd3
  } walk_phase_t;

  typedef struct packed {
    logic              mode;
    logic [IDX_W-1:0]  block_index;
    logic              large_file;
    logic [63:0]       addr_slots_low;
    logic [63:0]       addr_slots_mid;
    logic [31:0]       addr_slots_high;
    logic [WORD_W-1:0] read_word;
    logic              read_ok;
  } imbw_item_t;

  typedef struct packed {
    logic              kind;
    logic [WORD_W-1:0] read_sector;
    logic [WIDX_W-1:0] read_word_index;
    logic [WORD_W-1:0] physical_block;
    logic [STAT_W-1:0] status;
  } imbw_result_t;

endpackage

[hdl/imbw_in_stage.sv]
// ----------------------------------------------------------------------------
// imbw_in_stage - input register of the walker
// Captures one beat from the input stream and holds it until the step
// logic consumes it.
// ----------------------------------------------------------------------------
module imbw_in_stage (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [imbw_pkg::IN_DATA_W-1:0]    in_tdata,
  input  logic                              in_tuser,
  input  logic                              advance,
  output logic                              item_valid,
  output imbw_pkg::imbw_item_t              item
);
  import imbw_pkg::*;

  logic       valid_r;
  imbw_item_t item_r;
  imbw_item_t item_nxt;

  assign in_tready  = !valid_r || advance;
  assign item_valid = valid_r;
  assign item       = item_r;

  // unpack the beat, lowest field first
  always_comb begin
    item_nxt.mode            = in_tuser;
    item_nxt.block_index     = in_tdata[16:0];
    item_nxt.large_file      = in_tdata[17];
    item_nxt.addr_slots_low  = in_tdata[81:18];
    item_nxt.addr_slots_mid  = in_tdata[145:82];
    item_nxt.addr_slots_high = in_tdata[177:146];
    item_nxt.read_word       = in_tdata[193:178];
    item_nxt.read_ok         = in_tdata[194];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_tready) begin
      valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r <= item_nxt;
    end
  end

endmodule

[hdl/imbw_step.sv]
// ----------------------------------------------------------------------------
// imbw_step - walk state and per-beat decision
// Decodes a lookup or a pointer-word response against the walk phase and
// produces at most one result; phase and saved inner index update on use.
// ----------------------------------------------------------------------------
module imbw_step (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   advance,
  input  imbw_pkg::imbw_item_t   item,
  output logic                   res_valid,
  output imbw_pkg::imbw_result_t res
);
  import imbw_pkg::*;

  walk_phase_t       phase_r, phase_nxt;
  logic [WIDX_W-1:0] pending_r, pending_nxt;

  logic [WORD_W-1:0] slots [SLOT_COUNT];

  // request decode
  logic [IDX_W-1:0]      idx;
  logic [IDX_W-1:0]      sm_rel1, sm_rel2, lg_rel, dbl_rel;
  logic                  sm_direct, sm_single, sm_double;
  logic                  lg_single, lg_double;
  logic [SLOT_IDX_W-1:0] sel_slot;
  logic [WORD_W-1:0]     sel_val;
  logic                  req_ask;
  walk_phase_t           req_phase;
  logic [WORD_W-1:0]     req_sector;
  logic [WIDX_W-1:0]     req_widx;
  logic [WORD_W-1:0]     req_blk;
  logic [STAT_W-1:0]     req_status;
  logic                  req_set_pending;
  logic [WIDX_W-1:0]     req_pending;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      slots[i]     = item.addr_slots_low[16*i +: 16];
      slots[i + 4] = item.addr_slots_mid[16*i +: 16];
    end
    slots[8] = item.addr_slots_high[15:0];
    slots[9] = item.addr_slots_high[31:16];
  end

  always_comb begin
    idx     = item.block_index;
    sm_rel1 = idx - IDX_W'(DIRECT_SLOTS);
    sm_rel2 = idx - IDX_W'(DIRECT_SLOTS + PTRS_PER_BLOCK);
    lg_rel  = idx - IDX_W'(LARGE_SINGLE_SPAN);

    sm_direct = !item.large_file && (32'(idx) < DIRECT_SLOTS);
    sm_single = !item.large_file && !sm_direct && (32'(sm_rel1) < PTRS_PER_BLOCK);
    sm_double = !item.large_file && (32'(idx) >= DIRECT_SLOTS + PTRS_PER_BLOCK)
                && (32'(sm_rel2) < DOUBLE_SPAN);
    lg_single = item.large_file && (32'(idx) < LARGE_SINGLE_SPAN);
    lg_double = item.large_file && !lg_single && (32'(lg_rel) < DOUBLE_SPAN);
    dbl_rel   = item.large_file ? lg_rel : sm_rel2;

    if (sm_direct)      sel_slot = SLOT_IDX_W'(idx);
    else if (sm_single) sel_slot = SLOT_IDX_W'(SMALL_SINGLE_SLOT);
    else if (sm_double) sel_slot = SLOT_IDX_W'(SMALL_DOUBLE_SLOT);
    else if (lg_single) sel_slot = SLOT_IDX_W'(idx >> PPB_BITS);
    else                sel_slot = SLOT_IDX_W'(LARGE_DOUBLE_SLOT);
    sel_val = slots[sel_slot];

    req_ask         = 1'b0;
    req_phase       = PH_IDLE;
    req_sector      = '0;
    req_widx        = '0;
    req_blk         = '0;
    req_status      = ST_OK;
    req_set_pending = 1'b0;
    req_pending     = WIDX_W'(dbl_rel[PPB_BITS-1:0]);

    if (sm_direct) begin
      req_blk = sel_val;
    end else if ((sm_single || lg_single) && sel_val != '0) begin
      // zero slot is a hole, answered right away
      req_ask    = 1'b1;
      req_phase  = PH_SINGLE;
      req_sector = sel_val;
      req_widx   = sm_single ? WIDX_W'(sm_rel1) : WIDX_W'(idx[PPB_BITS-1:0]);
    end else if ((sm_double || lg_double) && sel_val != '0) begin
      req_ask         = 1'b1;
      req_phase       = PH_OUTER;
      req_sector      = sel_val;
      req_widx        = WIDX_W'(dbl_rel >> PPB_BITS);
      req_set_pending = 1'b1;
    end else if (!(sm_single || lg_single || sm_double || lg_double)) begin
      req_status = ST_RANGE;
    end
  end

  // next state
  always_comb begin
    phase_nxt   = phase_r;
    pending_nxt = pending_r;
    if (item.mode == MODE_LOOKUP) begin
      phase_nxt = req_phase;
      if (req_set_pending) pending_nxt = req_pending;
    end else begin
      case (phase_r)
        PH_IDLE:  phase_nxt = PH_IDLE;
        PH_OUTER: phase_nxt = (item.read_ok && item.read_word != '0) ? PH_INNER : PH_IDLE;
        default:  phase_nxt = PH_IDLE;
      endcase
    end
  end

  // result
  always_comb begin
    res_valid           = 1'b1;
    res.kind            = KIND_ANSWER;
    res.read_sector     = '0;
    res.read_word_index = '0;
    res.physical_block  = '0;
    res.status          = ST_OK;
    if (item.mode == MODE_LOOKUP) begin
      res.kind            = req_ask ? KIND_READ_REQ : KIND_ANSWER;
      res.read_sector     = req_sector;
      res.read_word_index = req_widx;
      res.physical_block  = req_blk;
      res.status          = req_status;
    end else begin
      case (phase_r)
        PH_IDLE: begin
          res_valid = 1'b0;   // stray response
        end
        PH_OUTER: begin
          if (!item.read_ok) begin
            res.status = ST_READ_FAIL;
          end else if (item.read_word != '0) begin
            res.kind            = KIND_READ_REQ;
            res.read_sector     = item.read_word;
            res.read_word_index = pending_r;
          end
        end
        default: begin
          if (!item.read_ok) res.status = ST_READ_FAIL;
          else               res.physical_block = item.read_word;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      pending_r <= '0;
    end else if (advance) begin
      phase_r   <= phase_nxt;
      pending_r <= pending_nxt;
    end
  end

endmodule

[hdl/inode_block_map_walker.sv]
// ----------------------------------------------------------------------------
// inode_block_map_walker - logical to physical file block lookup
// Walks an inode's direct, single- and double-indirect address slots one
// pointer word at a time.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream: a beat with tuser = 0 starts a lookup (block index, layout
//   flag and the ten address slots); a beat with tuser = 1 returns the
//   pointer word asked for by the previous read request, with its ok flag.
//   Output stream: tuser = 0 is a read request (sector, word index) that the
//   caller serves and answers with a response beat; tuser = 1 is the final
//   answer (physical block, status). Each beat gives at most one result; a
//   response that arrives with no walk pending gives none.
//   One beat per cycle is sustained while out_tready is high: the input
//   register feeds a single level of decode and slot select into the output
//   register, which drives out_tvalid.
//   A new lookup drops any walk in progress.
//   Stall: while out_tvalid waits on out_tready, the result stays put; the
//   input register takes one more beat if empty, then in_tready drops.
//   Reset (rst_n low, synchronous): both registers empty, walk idle.
// ----------------------------------------------------------------------------
module inode_block_map_walker (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // block_index[16:0], large_file[17], addr_slots_low[81:18],
  // addr_slots_mid[145:82], addr_slots_high[177:146], read_word[193:178],
  // read_ok[194], zero pad [199:195]
  input  logic [imbw_pkg::IN_DATA_W-1:0]      in_tdata,
  // mode
  input  logic                                in_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // read_sector[15:0], read_word_index[23:16], physical_block[39:24],
  // status[41:40], zero pad [47:42]
  output logic [imbw_pkg::OUT_DATA_W-1:0]     out_tdata,
  // kind
  output logic                                out_tuser
);
  import imbw_pkg::*;

  logic         s1_valid;
  imbw_item_t   s1_item;
  logic         advance;
  logic         step_res_valid;
  imbw_result_t step_res;

  logic         out_valid_r, out_valid_nxt;
  imbw_result_t out_res_r;

  // the input beat moves on when the output register is free or draining
  assign advance = s1_valid && (!out_valid_r || out_tready);

  imbw_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .advance    (advance),
    .item_valid (s1_valid),
    .item       (s1_item)
  );

  imbw_step u_step (
    .clk       (clk),
    .rst_n     (rst_n),
    .advance   (advance),
    .item      (s1_item),
    .res_valid (step_res_valid),
    .res       (step_res)
  );

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (!out_valid_r || out_tready) out_valid_nxt = advance && step_res_valid;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && step_res_valid) begin
      out_res_r <= step_res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_res_r.kind;
  assign out_tdata  = {6'd0, out_res_r.status, out_res_r.physical_block,
                       out_res_r.read_word_index, out_res_r.read_sector};

  // every lookup yields a result beat
  a_lookup_answers: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && s1_item.mode == MODE_LOOKUP) |-> step_res_valid)
    else $error("lookup beat produced no result");

  // a held input beat is not lost while the output is blocked
  a_hold_input: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid && !advance) |=> s1_valid)
    else $error("input beat dropped during stall");

  // error answers carry no block number
  a_error_zero_block: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_res_r.kind == KIND_ANSWER && out_res_r.status != ST_OK)
      |-> (out_res_r.physical_block == '0))
    else $error("error answer with nonzero block");

endmodule
